/* hdl/transfer_table_interpolator_core_assert.svh */
// Assertion macros for the transfer table interpolator checker.
`ifndef TRANSFER_TABLE_INTERPOLATOR_CORE_ASSERT_SVH
`define TRANSFER_TABLE_INTERPOLATOR_CORE_ASSERT_SVH

// Consequent checked in the cycle after the antecedent.
`define TTIC_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

// Consequent checked with an added delay after the non-overlapping implication.
`define TTIC_ASSERT_NEXT2(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> ##1 (cons)) \
		else $error(msg);

`endif

/* hdl/ttic_pkg.sv */
// Shared constants, types and request structs of the transfer table interpolator.
`default_nettype none

package ttic_pkg;

	localparam int TABLE_ENTRIES = 256;
	localparam int CHANNEL_BITS  = 16;

	localparam int POS_W     = 8;
	localparam int CHAN_W    = 16;
	localparam int NUM_CHAN  = 4;
	localparam int WORD_W    = NUM_CHAN * CHAN_W;
	localparam int FRAC_BITS = 16;

	// positions above 255 can never be addressed
	localparam int MEM_DEPTH = (TABLE_ENTRIES < (1 << POS_W)) ? TABLE_ENTRIES : (1 << POS_W);
	localparam int IDX_W     = (MEM_DEPTH > 1) ? $clog2(MEM_DEPTH) : 1;

	localparam int Q_W     = CHAN_W + FRAC_BITS;
	localparam int CNT_W   = $clog2(Q_W);
	localparam int SLOPE_W = Q_W + 1;
	localparam int ACC_W   = SLOPE_W + 1;
	localparam int INT_W   = ACC_W - 1 - FRAC_BITS;

	localparam logic [CHAN_W-1:0] CHAN_MASK = CHAN_W'((32'd1 << CHANNEL_BITS) - 32'd1);

	localparam logic [1:0] CMD_FIRST = 2'd0;
	localparam logic [1:0] CMD_NEXT  = 2'd1;
	localparam logic [1:0] CMD_READ  = 2'd2;

	typedef logic [POS_W-1:0]  pos_t;
	typedef logic [IDX_W-1:0]  idx_t;
	typedef logic [CHAN_W-1:0] chan_t;
	typedef logic [WORD_W-1:0] word_t;

	typedef struct packed {
		logic  we;
		idx_t  waddr;
		word_t wdata;
		logic  re;
		idx_t  raddr;
	} tbl_req_t;

	typedef struct packed {
		logic           start;
		logic           neg;
		logic [Q_W-1:0] num;
		pos_t           den;
	} div_req_t;

endpackage

`default_nettype wire

/* hdl/ttic_div.sv */
// Bit-serial restoring divider producing one signed segment slope.
`default_nettype none

module ttic_div (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire ttic_pkg::div_req_t                  req,
	output logic                                     busy,
	output logic signed [ttic_pkg::SLOPE_W-1:0]      slope
);
	import ttic_pkg::*;

	logic              busy_q;
	logic [CNT_W-1:0]  cnt_q;
	logic [Q_W-1:0]    num_q;
	logic [Q_W-1:0]    quo_q;
	pos_t              rem_q;
	pos_t              den_q;
	logic              neg_q;
	logic [POS_W:0]    trial;
	logic [POS_W:0]    diff;
	logic              take;
	logic [SLOPE_W-1:0] mag_ext;

	assign trial = {rem_q, num_q[Q_W-1]};
	assign diff  = trial - {1'b0, den_q};
	assign take  = (trial >= {1'b0, den_q});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (req.start) begin
			busy_q <= 1'b1;
			cnt_q  <= '0;
		end else if (busy_q) begin
			if (cnt_q == CNT_W'(Q_W - 1))
				busy_q <= 1'b0;
			cnt_q <= cnt_q + 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			num_q <= req.num;
			den_q <= req.den;
			neg_q <= req.neg;
			rem_q <= '0;
			quo_q <= '0;
		end else if (busy_q) begin
			num_q <= {num_q[Q_W-2:0], 1'b0};
			rem_q <= take ? diff[POS_W-1:0] : trial[POS_W-1:0];
			quo_q <= {quo_q[Q_W-2:0], take};
		end
	end

	assign mag_ext = {1'b0, quo_q};
	assign slope   = neg_q ? -mag_ext : mag_ext;
	assign busy    = busy_q;

endmodule

`default_nettype wire

/* hdl/ttic_table.sv */
// Transfer table memory with per-entry valid bits and registered read.
`default_nettype none

module ttic_table (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire ttic_pkg::tbl_req_t req,
	output ttic_pkg::word_t         rdata
);
	import ttic_pkg::*;

	word_t                mem [MEM_DEPTH];
	logic [MEM_DEPTH-1:0] valid_q;
	word_t                rdata_q;
	logic                 hit_q;

	always_ff @(posedge clk) begin
		if (req.we)
			mem[req.waddr] <= req.wdata;
		if (req.re)
			rdata_q <= mem[req.raddr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
			hit_q   <= 1'b0;
		end else begin
			if (req.we)
				valid_q[req.waddr] <= 1'b1;
			if (req.re)
				hit_q <= valid_q[req.raddr];
		end
	end

	// never-written entries read as zero
	assign rdata = hit_q ? rdata_q : '0;

endmodule

`default_nettype wire

/* hdl/transfer_table_interpolator_core.sv */
// Top level of the transfer table interpolator: command decode, segment fill and response.
// Usage:
//   Command channel (cmd_valid/cmd_stall) carries command, position and four channel
//   values. Command 0 starts a curve with a control point, command 1 adds the next
//   point, command 2 reads one table entry, command 3 is ignored.
//   Response channel (rsp_valid/rsp_stall) returns the four channels of a read entry.
// Timing:
//   A point that opens no segment leaves cmd_stall low. A command 1 point above the previous one
//   runs four parallel 32-step restoring dividers (one per channel, one quotient bit per
//   cycle), then writes one interpolated entry per cycle through the table's single
//   write port.
//   A read passes through the table's read register, then into the response register.
//   cmd_stall is high while a segment fill or a read is in progress.
// Reset:
//   Clears curve state and the table valid bits, so every entry reads as zero.
// Backpressure:
//   A held response does not block writes; a following read waits for the response
//   register to drain before it completes.
`default_nettype none

module transfer_table_interpolator_core (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cmd_valid,
	output logic             cmd_stall,
	input  wire logic [1:0]  command,
	input  wire logic [7:0]  position,
	input  wire logic [15:0] red_in,
	input  wire logic [15:0] green_in,
	input  wire logic [15:0] blue_in,
	input  wire logic [15:0] alpha_in,
	output logic             rsp_valid,
	input  wire logic        rsp_stall,
	output logic [15:0]      red_out,
	output logic [15:0]      green_out,
	output logic [15:0]      blue_out,
	output logic [15:0]      alpha_out
);
	import ttic_pkg::*;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DIVIDE,
		ST_FILL,
		ST_DRAIN,
		ST_RDATA
	} state_t;

	localparam logic [FRAC_BITS-1:0] ROUND_HALF = FRAC_BITS'(1) << (FRAC_BITS - 1);

	state_t   state_q;
	logic     accept;
	logic     is_wr;
	logic     is_rd;
	logic     pos_ok;
	logic     start_fill;
	logic     issue;
	logic     j_ok;
	word_t    in_word;
	word_t    fill_word;
	word_t    rdata;
	tbl_req_t tbl_req;

	pos_t     last_pos_q;
	word_t    last_word_q;
	logic     have_last_q;
	pos_t     j_q;
	pos_t     p2_q;
	logic     rd_ok_q;
	logic     rsp_valid_q;
	chan_t    red_q, green_q, blue_q, alpha_q;
	logic     fill_vld_s1;
	idx_t     fill_addr_s1;

	logic [NUM_CHAN-1:0]      div_busy;
	logic signed [SLOPE_W-1:0] slope [NUM_CHAN];

	function automatic chan_t chan_val(input logic signed [ACC_W-1:0] acc);
		chan_t r;
		if (acc[ACC_W-1])
			r = '0;
		else if (acc[ACC_W-2:FRAC_BITS] > INT_W'(CHAN_MASK))
			r = CHAN_MASK;
		else
			r = acc[FRAC_BITS+CHAN_W-1:FRAC_BITS];
		return r;
	endfunction

	assign cmd_stall  = (state_q != ST_IDLE);
	assign accept     = cmd_valid & ~cmd_stall;
	assign is_wr      = accept && (command == CMD_FIRST || command == CMD_NEXT);
	assign is_rd      = accept && (command == CMD_READ);
	assign pos_ok     = (32'(position) < TABLE_ENTRIES);
	assign start_fill = is_wr && (command == CMD_NEXT) && have_last_q &&
	                    (position > last_pos_q);
	assign issue      = (state_q == ST_FILL) && (j_q < p2_q);
	assign j_ok       = (32'(j_q) < TABLE_ENTRIES);

	assign in_word = {alpha_in & CHAN_MASK, blue_in & CHAN_MASK,
	                  green_in & CHAN_MASK, red_in & CHAN_MASK};

	for (genvar c = 0; c < NUM_CHAN; c++) begin : g_lane
		chan_t                     a;
		chan_t                     b;
		logic [CHAN_W:0]           diff;
		chan_t                     mag;
		div_req_t                  dreq;
		logic signed [ACC_W-1:0]   acc_q;

		assign a    = last_word_q[c*CHAN_W +: CHAN_W];
		assign b    = in_word[c*CHAN_W +: CHAN_W];
		assign diff = {1'b0, b} - {1'b0, a};
		assign mag  = diff[CHAN_W] ? CHAN_W'(-diff) : diff[CHAN_W-1:0];

		assign dreq.start = start_fill;
		assign dreq.neg   = diff[CHAN_W];
		assign dreq.num   = {mag, {FRAC_BITS{1'b0}}};
		assign dreq.den   = position - last_pos_q;

		ttic_div u_div (
			.clk    (clk),
			.arst_n (arst_n),
			.req    (dreq),
			.busy   (div_busy[c]),
			.slope  (slope[c])
		);

		// accumulator holds value plus rounding half, in Q.16
		always_ff @(posedge clk) begin
			if (start_fill)
				acc_q <= {{(ACC_W-CHAN_W-FRAC_BITS){1'b0}}, a, ROUND_HALF};
			else if (issue)
				acc_q <= acc_q + {slope[c][SLOPE_W-1], slope[c]};
		end

		assign fill_word[c*CHAN_W +: CHAN_W] = chan_val(acc_q);
	end

	always_comb begin
		tbl_req = '0;
		if (fill_vld_s1) begin
			tbl_req.we    = 1'b1;
			tbl_req.waddr = fill_addr_s1;
			tbl_req.wdata = fill_word;
		end else if (is_wr && pos_ok) begin
			tbl_req.we    = 1'b1;
			tbl_req.waddr = IDX_W'(position);
			tbl_req.wdata = in_word;
		end
		tbl_req.re    = is_rd && pos_ok;
		tbl_req.raddr = IDX_W'(position);
	end

	ttic_table u_table (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (tbl_req),
		.rdata  (rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			last_pos_q   <= '0;
			last_word_q  <= '0;
			have_last_q  <= 1'b0;
			j_q          <= '0;
			p2_q         <= '0;
			rd_ok_q      <= 1'b0;
			rsp_valid_q  <= 1'b0;
			red_q        <= '0;
			green_q      <= '0;
			blue_q       <= '0;
			alpha_q      <= '0;
			fill_vld_s1  <= 1'b0;
			fill_addr_s1 <= '0;
		end else begin
			fill_vld_s1  <= issue && j_ok;
			fill_addr_s1 <= IDX_W'(j_q);

			if (rsp_valid_q && !rsp_stall && state_q != ST_RDATA)
				rsp_valid_q <= 1'b0;

			if (is_wr) begin
				last_pos_q  <= position;
				last_word_q <= in_word;
				have_last_q <= 1'b1;
			end

			case (state_q)
				ST_IDLE: begin
					if (start_fill) begin
						state_q <= ST_DIVIDE;
						j_q     <= last_pos_q + 1'b1;
						p2_q    <= position;
					end else if (is_rd) begin
						state_q <= ST_RDATA;
						rd_ok_q <= pos_ok;
					end
				end
				ST_DIVIDE: begin
					if (div_busy == '0)
						state_q <= ST_FILL;
				end
				ST_FILL: begin
					if (issue)
						j_q <= j_q + 1'b1;
					else
						state_q <= ST_DRAIN;
				end
				ST_DRAIN: begin
					state_q <= ST_IDLE;
				end
				ST_RDATA: begin
					if (!rsp_valid_q || !rsp_stall) begin
						rsp_valid_q <= 1'b1;
						red_q       <= rd_ok_q ? rdata[0*CHAN_W +: CHAN_W] : '0;
						green_q     <= rd_ok_q ? rdata[1*CHAN_W +: CHAN_W] : '0;
						blue_q      <= rd_ok_q ? rdata[2*CHAN_W +: CHAN_W] : '0;
						alpha_q     <= rd_ok_q ? rdata[3*CHAN_W +: CHAN_W] : '0;
						state_q     <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign red_out   = red_q;
	assign green_out = green_q;
	assign blue_out  = blue_q;
	assign alpha_out = alpha_q;

endmodule

`default_nettype wire

/* hdl/ttic_chk.sv */
// Port-level checker for the transfer table interpolator and its bind.
`default_nettype none
`include "transfer_table_interpolator_core_assert.svh"

module ttic_chk (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cmd_valid,
	input  wire logic        cmd_stall,
	input  wire logic [1:0]  command,
	input  wire logic        rsp_valid,
	input  wire logic        rsp_stall,
	input  wire logic [15:0] red_out,
	input  wire logic [15:0] green_out,
	input  wire logic [15:0] blue_out,
	input  wire logic [15:0] alpha_out
);
	import ttic_pkg::*;

	logic acc;
	assign acc = cmd_valid && !cmd_stall;

	`TTIC_ASSERT_NEXT(a_rsp_hold, rsp_valid && rsp_stall, rsp_valid && $stable(red_out) && $stable(green_out) && $stable(blue_out) && $stable(alpha_out), "stalled response changed")
	`TTIC_ASSERT_NEXT(a_first_fast, acc && command == CMD_FIRST, !cmd_stall, "first point did not complete in one cycle")
	`TTIC_ASSERT_NEXT(a_read_busy, acc && command == CMD_READ, cmd_stall, "read transaction not held")
	`TTIC_ASSERT_NEXT2(a_read_lat, acc && command == CMD_READ && !rsp_valid, rsp_valid, "read response late")

endmodule

bind transfer_table_interpolator_core ttic_chk u_ttic_chk (
	.clk       (clk),
	.arst_n    (arst_n),
	.cmd_valid (cmd_valid),
	.cmd_stall (cmd_stall),
	.command   (command),
	.rsp_valid (rsp_valid),
	.rsp_stall (rsp_stall),
	.red_out   (red_out),
	.green_out (green_out),
	.blue_out  (blue_out),
	.alpha_out (alpha_out)
);

`default_nettype wire

/* tb/sv/transfer_table_interpolator_core_test.sv */
// Self-checking testbench of the transfer table interpolator: point writes, segment fills, reads.
`timescale 1ns / 100ps

module transfer_table_interpolator_core_test;
	import ttic_pkg::*;

	localparam logic [1:0] CMD_SKIP = 2'd3;
	localparam int QUIET_LIMIT = 4000;
	localparam int LONG_HOLD = 300;
	localparam int SETTLE_CYCLES = 320;

	typedef struct packed {
		logic [1:0] cmd;
		pos_t       pos;
		word_t      vals;
		logic       typed;
		word_t      want;
	} dir_row_t;

	logic        clk;
	logic        arst_n = 1'b0;
	logic        cmd_valid = 1'b0;
	logic        cmd_stall;
	logic [1:0]  command = CMD_FIRST;
	logic [7:0]  position = '0;
	logic [15:0] red_in = '0;
	logic [15:0] green_in = '0;
	logic [15:0] blue_in = '0;
	logic [15:0] alpha_in = '0;
	logic        rsp_valid;
	logic        rsp_stall = 1'b0;
	logic [15:0] red_out;
	logic [15:0] green_out;
	logic [15:0] blue_out;
	logic [15:0] alpha_out;

	// curve state of the predictor
	word_t curve_tbl [TABLE_ENTRIES];
	pos_t  prev_pos;
	word_t prev_vals;
	bit    have_prev;

	word_t    pending_reads [$];
	dir_row_t dir_rows [$];
	int       mismatches = 0;
	int       sent = 0;
	int       send_idle_pct = 0;
	int       rcv_stall_pct = 0;
	bit       long_hold_go = 1'b0;
	bit       long_hold_done = 1'b0;
	int       hold_left = 0;

	transfer_table_interpolator_core DUT (
		.clk(clk),
		.arst_n(arst_n),
		.cmd_valid(cmd_valid),
		.cmd_stall(cmd_stall),
		.command(command),
		.position(position),
		.red_in(red_in),
		.green_in(green_in),
		.blue_in(blue_in),
		.alpha_in(alpha_in),
		.rsp_valid(rsp_valid),
		.rsp_stall(rsp_stall),
		.red_out(red_out),
		.green_out(green_out),
		.blue_out(blue_out),
		.alpha_out(alpha_out)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	function automatic word_t pack_chan(chan_t r, chan_t g, chan_t b, chan_t a);
		return {a, b, g, r};
	endfunction

	function automatic chan_t round_level(longint acc);
		longint r;
		r = acc + 32768;
		if (r < 0)
			return '0;
		r = r >>> FRAC_BITS;
		if (r > longint'(CHAN_MASK))
			r = longint'(CHAN_MASK);
		return chan_t'(r);
	endfunction

	function automatic chan_t rand_level();
		case ($urandom_range(7))
			0: return '0;
			1: return 16'hffff;
			2: return chan_t'($urandom_range(255));
			3: return chan_t'(16'hff00 + $urandom_range(255));
			default: return chan_t'($urandom);
		endcase
	endfunction

	function automatic word_t rand_point();
		return pack_chan(rand_level(), rand_level(), rand_level(), rand_level());
	endfunction

	task automatic store_word(int idx, word_t w);
		if (idx < TABLE_ENTRIES)
			curve_tbl[idx] = w;
	endtask

	task automatic fill_span(pos_t p2, word_t v2);
		longint d;
		longint a;
		longint b;
		longint slope [NUM_CHAN];
		longint acc [NUM_CHAN];
		word_t  w;
		d = longint'(p2) - longint'(prev_pos);
		for (int c = 0; c < NUM_CHAN; c++) begin
			a = longint'(prev_vals[CHAN_W*c +: CHAN_W]);
			b = longint'(v2[CHAN_W*c +: CHAN_W]);
			slope[c] = ((b - a) * 65536) / d;
			acc[c] = a * 65536;
		end
		for (int j = int'(prev_pos) + 1; j < int'(p2); j++) begin
			for (int c = 0; c < NUM_CHAN; c++) begin
				acc[c] += slope[c];
				w[CHAN_W*c +: CHAN_W] = round_level(acc[c]);
			end
			store_word(j, w);
		end
	endtask

	task automatic predict_entry(logic [1:0] cmd, pos_t pos, word_t vals,
			output bit has_rsp, output word_t rsp);
		word_t masked;
		has_rsp = 1'b0;
		rsp = '0;
		if (cmd == CMD_READ) begin
			has_rsp = 1'b1;
			if (pos < TABLE_ENTRIES)
				rsp = curve_tbl[pos];
		end else if (cmd != CMD_SKIP) begin
			for (int c = 0; c < NUM_CHAN; c++)
				masked[CHAN_W*c +: CHAN_W] = vals[CHAN_W*c +: CHAN_W] & CHAN_MASK;
			store_word(pos, masked);
			if (cmd == CMD_NEXT && have_prev && pos > prev_pos)
				fill_span(pos, masked);
			prev_pos = pos;
			prev_vals = masked;
			have_prev = 1'b1;
		end
	endtask

	task automatic send_cmd(logic [1:0] cmd, pos_t pos, word_t vals,
			bit typed = 1'b0, word_t want = '0);
		bit    has_rsp;
		word_t rsp;
		while ($urandom_range(99) < send_idle_pct) begin
			cmd_valid <= 1'b0;
			@(posedge clk);
		end
		cmd_valid <= 1'b1;
		command <= cmd;
		position <= pos;
		red_in <= vals[15:0];
		green_in <= vals[31:16];
		blue_in <= vals[47:32];
		alpha_in <= vals[63:48];
		do
			@(posedge clk);
		while (cmd_stall);
		predict_entry(cmd, pos, vals, has_rsp, rsp);
		if (has_rsp)
			pending_reads.push_back(typed ? want : rsp);
		if (cmd != CMD_SKIP)
			sent++;
	endtask

	task automatic add_row(logic [1:0] cmd, pos_t pos, word_t vals,
			bit typed = 1'b0, word_t want = '0);
		dir_row_t row;
		row.cmd = cmd;
		row.pos = pos;
		row.vals = vals;
		row.typed = typed;
		row.want = want;
		dir_rows.push_back(row);
	endtask

	task automatic drain_reads();
		cmd_valid <= 1'b0;
		@(posedge clk);
		while (pending_reads.size() != 0)
			@(posedge clk);
	endtask

	task automatic run_random(int quota);
		int   stop;
		int   p;
		int   np;
		int   lim;
		int   steps;
		int   pick;
		stop = sent + quota;
		while (sent < stop) begin
			pick = $urandom_range(99);
			if (pick < 70) begin
				p = ($urandom_range(9) == 0) ? 0 : $urandom_range(200);
				send_cmd(CMD_FIRST, pos_t'(p), rand_point());
				steps = $urandom_range(1, 6);
				for (int k = 0; k < steps && p < 255; k++) begin
					lim = 255 - p;
					if ($urandom_range(9) == 0)
						np = p + $urandom_range(1, lim);
					else
						np = p + $urandom_range(1, (lim > 12) ? 12 : lim);
					send_cmd(CMD_NEXT, pos_t'(np), rand_point());
					if ($urandom_range(9) < 6) begin
						repeat ($urandom_range(1, 2))
							send_cmd(CMD_READ, pos_t'($urandom_range(p, np)), rand_point());
					end
					p = np;
				end
			end else if (pick < 80) begin
				send_cmd(CMD_SKIP, pos_t'($urandom_range(255)), rand_point());
			end else if (pick < 90) begin
				send_cmd(CMD_NEXT, pos_t'($urandom_range(int'(prev_pos))), rand_point());
			end else begin
				send_cmd(CMD_READ, pos_t'($urandom_range(255)), rand_point());
			end
		end
	endtask

	task automatic report_mismatch(string what, chan_t got, chan_t want);
		$display("mismatch %s: got %h, want %h", what, got, want);
		mismatches++;
	endtask

	always @(posedge clk) begin
		if (long_hold_go && !long_hold_done) begin
			long_hold_done <= 1'b1;
			hold_left <= LONG_HOLD;
			rsp_stall <= 1'b1;
		end else if (hold_left > 0) begin
			hold_left <= hold_left - 1;
			rsp_stall <= 1'b1;
		end else begin
			rsp_stall <= ($urandom_range(99) < rcv_stall_pct);
		end
	end

	always @(posedge clk) begin
		word_t want;
		if (arst_n && rsp_valid && !rsp_stall) begin
			if (pending_reads.size() == 0) begin
				report_mismatch("unrequested transaction, red", red_out, '0);
			end else begin
				want = pending_reads.pop_front();
				if (red_out !== want[15:0])
					report_mismatch("red", red_out, want[15:0]);
				if (green_out !== want[31:16])
					report_mismatch("green", green_out, want[31:16]);
				if (blue_out !== want[47:32])
					report_mismatch("blue", blue_out, want[47:32]);
				if (alpha_out !== want[63:48])
					report_mismatch("alpha", alpha_out, want[63:48]);
			end
		end
	end

	initial begin
		int quiet;
		quiet = 0;
		while (quiet < QUIET_LIMIT) begin
			@(posedge clk);
			if (!arst_n || (cmd_valid && !cmd_stall) || (rsp_valid && !rsp_stall))
				quiet = 0;
			else
				quiet++;
		end
		$display("TB_ERROR");
		$finish;
	end

	initial begin
		for (int i = 0; i < TABLE_ENTRIES; i++)
			curve_tbl[i] = '0;
		prev_pos = '0;
		prev_vals = '0;
		have_prev = 1'b0;

		add_row(CMD_READ, 8'd0, '0, 1'b1, '0);
		add_row(CMD_READ, 8'd255, '0, 1'b1, '0);
		add_row(CMD_SKIP, 8'd7, '1);
		add_row(CMD_READ, 8'd7, '0, 1'b1, '0);
		// next point with no curve open starts one
		add_row(CMD_NEXT, 8'd10, pack_chan(16'h1000, 16'h2000, 16'h3000, 16'h4000));
		add_row(CMD_READ, 8'd10, '0, 1'b1, pack_chan(16'h1000, 16'h2000, 16'h3000, 16'h4000));
		add_row(CMD_NEXT, 8'd20, pack_chan(16'hffff, 16'h0000, 16'h8000, 16'h1234));
		add_row(CMD_READ, 8'd15, '0);
		add_row(CMD_READ, 8'd20, '0, 1'b1, pack_chan(16'hffff, 16'h0000, 16'h8000, 16'h1234));
		// same and lower position: point only
		add_row(CMD_NEXT, 8'd20, pack_chan(16'h5555, 16'haaaa, 16'h0001, 16'hfffe));
		add_row(CMD_READ, 8'd20, '0, 1'b1, pack_chan(16'h5555, 16'haaaa, 16'h0001, 16'hfffe));
		add_row(CMD_NEXT, 8'd5, pack_chan(16'h0102, 16'h0304, 16'h0506, 16'h0708));
		add_row(CMD_READ, 8'd5, '0, 1'b1, pack_chan(16'h0102, 16'h0304, 16'h0506, 16'h0708));
		add_row(CMD_READ, 8'd12, '0);
		// full-length span
		add_row(CMD_FIRST, 8'd0, '0);
		add_row(CMD_NEXT, 8'd255, '1);
		add_row(CMD_READ, 8'd1, '0);
		add_row(CMD_READ, 8'd128, '0);
		add_row(CMD_READ, 8'd254, '0);
		add_row(CMD_READ, 8'd255, '0, 1'b1, '1);
		// falling slopes, with blue rising
		add_row(CMD_FIRST, 8'd30, pack_chan(16'hffff, 16'hffff, 16'h0000, 16'h8000));
		add_row(CMD_NEXT, 8'd60, pack_chan(16'h0000, 16'h0001, 16'hffff, 16'h7fff));
		add_row(CMD_READ, 8'd45, '0);
		add_row(CMD_READ, 8'd59, '0);
		// adjacent points, nothing between
		add_row(CMD_FIRST, 8'd100, '1);
		add_row(CMD_NEXT, 8'd101, '0);
		add_row(CMD_READ, 8'd100, '0, 1'b1, '1);
		add_row(CMD_READ, 8'd101, '0, 1'b1, '0);

		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_idle_pct = 20;
		rcv_stall_pct <= 83;
		foreach (dir_rows[i])
			send_cmd(dir_rows[i].cmd, dir_rows[i].pos, dir_rows[i].vals,
				dir_rows[i].typed, dir_rows[i].want);
		run_random(150);
		drain_reads();

		send_idle_pct = 83;
		rcv_stall_pct <= 20;
		run_random(150);
		drain_reads();

		send_idle_pct = 0;
		rcv_stall_pct <= 0;
		long_hold_go <= 1'b1;
		repeat (10)
			send_cmd(CMD_READ, pos_t'($urandom_range(255)), rand_point());
		run_random(140);
		drain_reads();
		repeat (SETTLE_CYCLES) @(posedge clk);

		if (mismatches == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule
